// File: rtl/assert_macros.svh
// assertion macros for the sha-256 hasher
// used by the top level; needs aclk and aresetn in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked every clock, off during reset
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the cycle after the antecedent
`define SHA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/sha_pkg.sv
// shared types, constants and round functions for the sha-256 hasher
// no dependencies
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DATA,
        ST_PAD,
        ST_ZERO,
        ST_LENLO,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        WR_DATA,
        WR_PAD,
        WR_ZERO,
        WR_LENHI,
        WR_LENLO
    } wr_sel_t;

    typedef struct packed {
        logic       load_in;
        logic       wr_en;
        wr_sel_t    wr_sel;
        logic       init_work;
        logic       round_en;
        logic [5:0] round_idx;
        logic       add_en;
        logic [2:0] out_idx;
        logic       msg_done;
    } cmd_t;

    typedef struct packed {
        logic [3:0] pos;
        logic       last;
        logic       cnt4;
    } status_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] PAD_WORD = 32'h80000000;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/sha_ctrl.sv
// sequencer for the sha-256 hasher: input beats, padding, rounds, digest beats
// depends on sha_pkg
module sha_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  sha_pkg::status_t  status,
    output sha_pkg::cmd_t     cmd
);

    sha_pkg::state_t state_reg, state_next;
    sha_pkg::state_t resume_reg, resume_next;
    logic [5:0]      round_reg, round_next;
    logic [2:0]      out_reg, out_next;
    sha_pkg::state_t after_wr;
    logic            wr_cycle;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sha_pkg::ST_IDLE;
            resume_reg <= sha_pkg::ST_IDLE;
            round_reg  <= '0;
            out_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            resume_reg <= resume_next;
            round_reg  <= round_next;
            out_reg    <= out_next;
        end
    end

    assign wr_cycle = (state_reg == sha_pkg::ST_DATA) || (state_reg == sha_pkg::ST_PAD) ||
                      (state_reg == sha_pkg::ST_ZERO) || (state_reg == sha_pkg::ST_LENLO);

    // next state
    always_comb begin
        state_next  = state_reg;
        resume_next = resume_reg;
        round_next  = '0;
        out_next    = out_reg;
        after_wr    = sha_pkg::ST_IDLE;
        unique case (state_reg)
            sha_pkg::ST_IDLE: begin
                if (s_valid) state_next = sha_pkg::ST_DATA;
            end
            sha_pkg::ST_DATA: begin
                if (!status.last) after_wr = sha_pkg::ST_IDLE;
                else if (status.cnt4) after_wr = sha_pkg::ST_PAD;
                else after_wr = sha_pkg::ST_ZERO;
            end
            sha_pkg::ST_PAD: after_wr = sha_pkg::ST_ZERO;
            sha_pkg::ST_ZERO: begin
                after_wr = (status.pos == 4'd14) ? sha_pkg::ST_LENLO : sha_pkg::ST_ZERO;
            end
            sha_pkg::ST_LENLO: after_wr = sha_pkg::ST_OUT;
            sha_pkg::ST_ROUND: begin
                round_next = round_reg + 6'd1;
                if (round_reg == 6'd63) state_next = sha_pkg::ST_ADD;
            end
            sha_pkg::ST_ADD: state_next = resume_reg;
            sha_pkg::ST_OUT: begin
                if (m_ready) begin
                    out_next = out_reg + 3'd1;
                    if (out_reg == 3'd7) state_next = sha_pkg::ST_IDLE;
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
        if (wr_cycle) begin
            // the sixteenth word of a block starts a compression
            if (status.pos == 4'd15) begin
                state_next  = sha_pkg::ST_ROUND;
                resume_next = after_wr;
            end else begin
                state_next = after_wr;
            end
        end
    end

    // outputs
    always_comb begin
        cmd           = '0;
        cmd.wr_sel    = sha_pkg::WR_DATA;
        cmd.round_idx = round_reg;
        cmd.out_idx   = out_reg;
        s_ready       = 1'b0;
        m_valid       = 1'b0;
        unique case (state_reg)
            sha_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.load_in = s_valid;
            end
            sha_pkg::ST_DATA:  cmd.wr_sel = sha_pkg::WR_DATA;
            sha_pkg::ST_PAD:   cmd.wr_sel = sha_pkg::WR_PAD;
            sha_pkg::ST_ZERO: begin
                cmd.wr_sel = (status.pos == 4'd14) ? sha_pkg::WR_LENHI : sha_pkg::WR_ZERO;
            end
            sha_pkg::ST_LENLO: cmd.wr_sel = sha_pkg::WR_LENLO;
            sha_pkg::ST_ROUND: cmd.round_en = 1'b1;
            sha_pkg::ST_ADD:   cmd.add_en = 1'b1;
            sha_pkg::ST_OUT: begin
                m_valid      = 1'b1;
                cmd.msg_done = m_ready && (out_reg == 3'd7);
            end
            default: ;
        endcase
        cmd.wr_en     = wr_cycle;
        cmd.init_work = wr_cycle && (status.pos == 4'd15);
    end

endmodule

// File: rtl/sha_dp.sv
// sha-256 datapath: block buffer with rolling schedule, round registers, hash words
// depends on sha_pkg
module sha_dp (
    input  logic              aclk,
    input  logic              aresetn,
    input  sha_pkg::cmd_t     cmd,
    input  logic [31:0]       s_message_word,
    input  logic [2:0]        s_byte_count,
    input  logic              s_first_word,
    input  logic              s_last_word,
    output sha_pkg::status_t  status,
    output logic [31:0]       m_digest_word
);

    logic [31:0] data_reg;
    logic [2:0]  cnt_reg;
    logic        last_reg;
    logic [63:0] bits_reg;
    logic [3:0]  pos_reg;
    logic [31:0] hash_reg [8];
    logic [31:0] buf_reg  [16];
    logic [31:0] wk_reg   [8];

    logic [2:0]  cnt_eff;
    logic [63:0] bits_base;
    logic [31:0] keep_mask, pad_bit, part_word, wr_word;
    logic [31:0] s0, s1, w_new;
    logic [31:0] t1, t2, ch, maj, sig0, sig1;

    // a partial word counts only on the last beat, and never above four bytes
    assign cnt_eff   = (s_last_word && s_byte_count <= 3'd4) ? s_byte_count : 3'd4;
    assign bits_base = s_first_word ? 64'd0 : bits_reg;

    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0: begin keep_mask = 32'h00000000; pad_bit = 32'h80000000; end
            2'd1: begin keep_mask = 32'hff000000; pad_bit = 32'h00800000; end
            2'd2: begin keep_mask = 32'hffff0000; pad_bit = 32'h00008000; end
            2'd3: begin keep_mask = 32'hffffff00; pad_bit = 32'h00000080; end
            default: begin keep_mask = 32'h0; pad_bit = 32'h0; end
        endcase
        part_word = (data_reg & keep_mask) | pad_bit;
        unique case (cmd.wr_sel)
            sha_pkg::WR_DATA:  wr_word = (!last_reg || cnt_reg == 3'd4) ? data_reg : part_word;
            sha_pkg::WR_PAD:   wr_word = sha_pkg::PAD_WORD;
            sha_pkg::WR_ZERO:  wr_word = 32'h0;
            sha_pkg::WR_LENHI: wr_word = bits_reg[63:32];
            sha_pkg::WR_LENLO: wr_word = bits_reg[31:0];
            default:           wr_word = 32'h0;
        endcase
    end

    // schedule: buf_reg[0] is w[t], the window slides one word per round
    always_comb begin
        s0 = sha_pkg::rotr(buf_reg[1], 7) ^ sha_pkg::rotr(buf_reg[1], 18) ^ (buf_reg[1] >> 3);
        s1 = sha_pkg::rotr(buf_reg[14], 17) ^ sha_pkg::rotr(buf_reg[14], 19)
             ^ (buf_reg[14] >> 10);
        w_new = s1 + buf_reg[9] + s0 + buf_reg[0];
        sig1 = sha_pkg::rotr(wk_reg[4], 6) ^ sha_pkg::rotr(wk_reg[4], 11)
               ^ sha_pkg::rotr(wk_reg[4], 25);
        sig0 = sha_pkg::rotr(wk_reg[0], 2) ^ sha_pkg::rotr(wk_reg[0], 13)
               ^ sha_pkg::rotr(wk_reg[0], 22);
        ch  = (wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]);
        maj = (wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]);
        t1  = wk_reg[7] + sig1 + ch + sha_pkg::round_k(cmd.round_idx) + buf_reg[0];
        t2  = sig0 + maj;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            bits_reg <= '0;
            for (int i = 0; i < 8; i++) hash_reg[i] <= sha_pkg::IV[i];
        end else begin
            if (cmd.load_in) begin
                bits_reg <= bits_base + {58'd0, cnt_eff, 3'b000};
                if (s_first_word) begin
                    pos_reg <= '0;
                    for (int i = 0; i < 8; i++) hash_reg[i] <= sha_pkg::IV[i];
                end
            end
            if (cmd.wr_en) pos_reg <= pos_reg + 4'd1;
            if (cmd.add_en) begin
                for (int i = 0; i < 8; i++) hash_reg[i] <= hash_reg[i] + wk_reg[i];
            end
            if (cmd.msg_done) begin
                pos_reg  <= '0;
                bits_reg <= '0;
                for (int i = 0; i < 8; i++) hash_reg[i] <= sha_pkg::IV[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            data_reg <= s_message_word;
            cnt_reg  <= cnt_eff;
            last_reg <= s_last_word;
        end
        if (cmd.wr_en) begin
            buf_reg[pos_reg] <= wr_word;
        end else if (cmd.round_en) begin
            for (int i = 0; i < 15; i++) buf_reg[i] <= buf_reg[i + 1];
            buf_reg[15] <= w_new;
        end
        if (cmd.init_work) begin
            for (int i = 0; i < 8; i++) wk_reg[i] <= hash_reg[i];
        end else if (cmd.round_en) begin
            wk_reg[0] <= t1 + t2;
            wk_reg[1] <= wk_reg[0];
            wk_reg[2] <= wk_reg[1];
            wk_reg[3] <= wk_reg[2];
            wk_reg[4] <= wk_reg[3] + t1;
            wk_reg[5] <= wk_reg[4];
            wk_reg[6] <= wk_reg[5];
            wk_reg[7] <= wk_reg[6];
        end
    end

    assign status.pos    = pos_reg;
    assign status.last   = last_reg;
    assign status.cnt4   = (cnt_reg == 3'd4);
    assign m_digest_word = hash_reg[cmd.out_idx];

endmodule

// File: rtl/sha256_message_hasher.sv
// sha-256 hasher: a word is registered, then written to the block buffer; a word that fills a block
// starts a compression (64 rounds, one add); a last word adds padding and one or two compressions
// (round loop), then eight digest beats, one per cycle while m_ready is high; input waits for idle
// synchronous active-low reset: idle, hash words at initial values, length and position zero
// the block buffer has no reset; every entry is written before a compression reads it
module sha256_message_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_message_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_first_word,
    input  logic        s_last_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic        m_digest_last
);

    sha_pkg::cmd_t    cmd;
    sha_pkg::status_t status;

    sha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sha_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .s_message_word (s_message_word),
        .s_byte_count   (s_byte_count),
        .s_first_word   (s_first_word),
        .s_last_word    (s_last_word),
        .status         (status),
        .m_digest_word  (m_digest_word)
    );

    assign m_digest_last = m_valid && (cmd.out_idx == 3'd7);

`include "assert_macros.svh"

    `SHA_ASSERT_IMP(a_no_overlap, m_valid, !s_ready, "input taken while digest pending")
    `SHA_ASSERT_NEXT(a_busy_after_beat, s_valid && s_ready, !s_ready, "two beats back to back")
    `SHA_ASSERT_NEXT(a_digest_ends, m_valid && m_ready && m_digest_last, !m_valid,
        "digest longer than eight beats")
    `SHA_ASSERT_IMP(a_round_clean, cmd.round_en, !cmd.wr_en && !m_valid,
        "buffer write during rounds")

endmodule
